FILE: src/tpps_pkg.sv
// Shared types and constants for the timer prescaler period search.
`timescale 1ns / 1ps

package tpps_pkg;

  localparam int unsigned CyclesW   = 32;
  localparam int unsigned FieldW    = 16;
  localparam int unsigned ResidualW = 17;

  localparam logic [FieldW-1:0]  FieldMax   = 16'hffff;
  localparam logic [FieldW-1:0]  PrescLimit = 16'hfffe;
  localparam logic [CyclesW-1:0] CyclesMax  = 32'hfffe_0001;  // 65535 * 65535

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIVC,
    ST_EVAL,
    ST_DONE
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic capture;      // take a new cycles beat
    logic set_p;        // p = ceil(n / FieldMax), arm the start pair
    logic start_div_c;  // divide n by p
    logic eval;         // score the candidate, step p
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic oor;       // captured count is out of range
    logic div_done;  // divider result valid this cycle
    logic stop;      // search ends after the current candidate
  } status_t;

endpackage

FILE: src/tpps_div.sv
// Iterative restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
`timescale 1ns / 1ps

module tpps_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tpps_pkg::CyclesW-1:0]   dividend_i,
  input  logic [tpps_pkg::FieldW-1:0]    divisor_i,
  output logic                           done_o,
  output logic [tpps_pkg::CyclesW-1:0]   quotient_o,
  output logic [tpps_pkg::FieldW-1:0]    remainder_o
);
  import tpps_pkg::*;

  localparam int unsigned CntW = $clog2(CyclesW);

  logic                active_q, active_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CyclesW-1:0]  quo_q, quo_d;
  logic [FieldW-1:0]   rem_q, rem_d;
  logic [FieldW-1:0]   dsr_q, dsr_d;
  logic [FieldW:0]     trial;
  logic [FieldW:0]     diff;

  assign trial = {rem_q, quo_q[CyclesW-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    dsr_d    = dsr_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = '1;
      quo_d    = dividend_i;
      rem_d    = '0;
      dsr_d    = divisor_i;
    end else if (active_q) begin
      // quotient register doubles as the dividend shift line
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = diff[FieldW-1:0];
        quo_d = {quo_q[CyclesW-2:0], 1'b1};
      end else begin
        rem_d = trial[FieldW-1:0];
        quo_d = {quo_q[CyclesW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

FILE: src/tpps_datapath.sv
// Datapath: captured count, candidate scoring, best-pair registers and the divider.
`timescale 1ns / 1ps

module tpps_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tpps_pkg::cmd_t                  cmd_i,
  output tpps_pkg::status_t               status_o,
  input  logic [tpps_pkg::CyclesW-1:0]    cycles_i,
  output logic [tpps_pkg::FieldW-1:0]     prescaler_o,
  output logic [tpps_pkg::FieldW-1:0]     counter_o,
  output logic signed [tpps_pkg::ResidualW-1:0] residual_o,
  output logic                            out_of_range_o
);
  import tpps_pkg::*;

  // one step of the upper half
  localparam logic [CyclesW-1:0] StartBias = 32'h0001_0000;

  logic [CyclesW-1:0]         n_q;
  logic                       oor_q;
  logic                       first_q;
  logic [FieldW-1:0]          p_q;
  logic [FieldW-1:0]          best_p_q, best_c_q;
  logic signed [ResidualW-1:0] best_res_q;
  logic [CyclesW-1:0]         best_mag_q;

  logic                       div_done;
  logic [CyclesW-1:0]         div_quo;
  logic [FieldW-1:0]          div_rem;

  // ceil(n / 65535) = (n + ((n-1) >> 16) + 65536) >> 16 over the valid range;
  // the sum tops out at 2^32-1, so no carry out is lost.
  logic [FieldW-1:0]          start_hi;
  logic [CyclesW-1:0]         start_sum;

  assign start_hi  = n_q[CyclesW-1:FieldW]
                   - {{(FieldW-1){1'b0}}, (n_q[FieldW-1:0] == '0)};
  assign start_sum = n_q + {{(CyclesW-FieldW){1'b0}}, start_hi} + StartBias;

  tpps_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.start_div_c),
    .dividend_i  (n_q),
    .divisor_i   (p_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Candidate for the current p; the quotient always fits 16 bits here.
  logic [FieldW-1:0]           c;
  logic                        round_up;
  logic                        reject;
  logic [FieldW-1:0]           cand_c;
  logic [FieldW-1:0]           cand_mag;
  logic signed [ResidualW-1:0] cand_res;
  logic [CyclesW-1:0]          bound;
  logic                        searching;
  logic                        better;
  logic                        exact;

  always_comb begin
    c         = div_quo[FieldW-1:0];
    round_up  = div_rem > {1'b0, p_q[FieldW-1:1]};
    reject    = round_up && (c == FieldMax);
    cand_c    = round_up ? c + 1'b1 : c;
    cand_mag  = round_up ? p_q - div_rem : div_rem;
    cand_res  = round_up ? $signed({1'b0, cand_mag}) : -$signed({1'b0, div_rem});
    bound     = first_q ? n_q : best_mag_q;
    searching = p_q < PrescLimit;
    better    = searching && !reject && ({{(CyclesW-FieldW){1'b0}}, cand_mag} < bound);
    exact     = better && (cand_mag == '0);
  end

  assign status_o.oor      = oor_q;
  assign status_o.div_done = div_done;
  assign status_o.stop     = !searching || exact || ((p_q + 1'b1) >= PrescLimit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oor_q   <= 1'b0;
      first_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        oor_q <= (cycles_i == '0) || (cycles_i > CyclesMax);
      end
      if (cmd_i.set_p) begin
        first_q <= 1'b1;
      end else if (cmd_i.eval) begin
        first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      n_q <= cycles_i;
    end
    if (cmd_i.set_p) begin
      p_q <= start_sum[CyclesW-1:FieldW];
    end else if (cmd_i.eval) begin
      p_q <= p_q + 1'b1;
    end
    if (cmd_i.eval) begin
      if (better) begin
        best_p_q   <= p_q;
        best_c_q   <= cand_c;
        best_res_q <= cand_res;
        best_mag_q <= {{(CyclesW-FieldW){1'b0}}, cand_mag};
      end else if (first_q) begin
        // start pair: first p with its unrounded count, bound stays at n
        best_p_q   <= p_q;
        best_c_q   <= c;
        best_res_q <= -$signed({1'b0, div_rem});
        best_mag_q <= n_q;
      end
    end
  end

  assign prescaler_o    = oor_q ? '0 : best_p_q;
  assign counter_o      = oor_q ? '0 : best_c_q;
  assign residual_o     = oor_q ? '0 : best_res_q;
  assign out_of_range_o = oor_q;

endmodule

FILE: src/tpps_ctrl.sv
// Controller: sequences range check, start prescaler, and the per-prescaler divide loop.
`timescale 1ns / 1ps

module tpps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  output tpps_pkg::cmd_t    cmd_o,
  input  tpps_pkg::status_t status_i
);
  import tpps_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_START;
        end
      end
      ST_START: begin
        // range verdict is registered by now
        if (status_i.oor) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.set_p = 1'b1;
          state_d     = ST_DIVC;
        end
      end
      ST_DIVC: begin
        cmd_o.start_div_c = 1'b1;
        state_d           = ST_EVAL;
      end
      ST_EVAL: begin
        if (status_i.div_done) begin
          cmd_o.eval = 1'b1;
          state_d    = status_i.stop ? ST_DONE : ST_DIVC;
        end
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/timer_prescaler_period_search_core.sv
// Top level: splits a cycle count into a 16-bit prescaler and a 16-bit period count.
`timescale 1ns / 1ps

// A count is taken when start is high and busy is low; the answer appears
// for exactly one cycle with done_o high and cannot be held off, so the
// receiver must take it then. The first prescaler comes from a shift-and-add;
// each candidate prescaler then costs one pass of a bit-serial 32-by-16
// divider. At least one candidate is scored, even when the search is empty.
// Worst case is 65533 candidates; an exact match ends the search early.
// Out-of-range counts (zero, or above 65535*65535) skip the search and go
// straight from the range check to the answer.
module timer_prescaler_period_search_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [tpps_pkg::CyclesW-1:0]           cycles_i,
  output logic                                   done_o,
  output logic [tpps_pkg::FieldW-1:0]            prescaler_o,
  output logic [tpps_pkg::FieldW-1:0]            counter_o,
  output logic signed [tpps_pkg::ResidualW-1:0]  residual_o,
  output logic                                   out_of_range_o
);
  import tpps_pkg::*;

  cmd_t    cmd;
  status_t status;

  tpps_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  tpps_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cycles_i       (cycles_i),
    .prescaler_o    (prescaler_o),
    .counter_o      (counter_o),
    .residual_o     (residual_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

FILE: tb/tb_timer_prescaler_period_search_core.sv
// Testbench for the timer prescaler period search core: directed and random counts.
`timescale 1ns / 1ps

module tb_timer_prescaler_period_search_core;

  import tpps_pkg::*;

  // Counts above this start the search within about 48 prescalers of the limit.
  localparam logic [CyclesW-1:0] TopBandLow = 32'd4291625011;  // 65486 * 65535 + 1

  typedef struct {
    logic [FieldW-1:0]           prescaler;
    logic [FieldW-1:0]           counter;
    logic signed [ResidualW-1:0] residual;
    logic                        out_of_range;
  } count_split_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic [CyclesW-1:0]          cycles_i;
  logic                        done_o;
  logic [FieldW-1:0]           prescaler_o;
  logic [FieldW-1:0]           counter_o;
  logic signed [ResidualW-1:0] residual_o;
  logic                        out_of_range_o;

  count_split_t expected_splits[$];
  int           failures = 0;
  bit           sender_idles = 1'b1;

  timer_prescaler_period_search_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cycles_i       (cycles_i),
    .done_o         (done_o),
    .prescaler_o    (prescaler_o),
    .counter_o      (counter_o),
    .residual_o     (residual_o),
    .out_of_range_o (out_of_range_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Best prescaler / period pair for a wanted count.
  function automatic count_split_t split_count(input logic [CyclesW-1:0] n);
    count_split_t      r;
    longint unsigned   nn, p, c, best_p, best_c, best_mag, mag;
    longint            err;
    r  = '{default: '0};
    nn = n;
    if (nn == 0 || nn > CyclesMax) begin
      r.out_of_range = 1'b1;
      return r;
    end
    p        = (nn - 1) / FieldMax + 1;
    best_p   = p;
    best_c   = nn / p;
    best_mag = nn;
    for (; p < PrescLimit; p++) begin
      c   = nn / p;
      err = longint'(p * c) - longint'(nn);
      mag = (err < 0) ? -err : err;
      if (mag > p / 2) begin
        if (c >= FieldMax) continue;  // round-up would not fit 16 bits
        c++;
        err = longint'(p * c) - longint'(nn);
        mag = (err < 0) ? -err : err;
      end
      if (mag < best_mag) begin
        best_mag = mag;
        best_p   = p;
        best_c   = c;
        if (err == 0) break;
      end
    end
    err         = longint'(best_p * best_c) - longint'(nn);
    r.prescaler = best_p[FieldW-1:0];
    r.counter   = best_c[FieldW-1:0];
    r.residual  = err[ResidualW-1:0];
    return r;
  endfunction

  // One beat on the command side; start stays high until the next call or the end.
  task automatic send_count(input logic [CyclesW-1:0] n);
    @(negedge clk_i);
    while (sender_idles && $urandom_range(99) < 16) begin
      start    = 1'b0;
      cycles_i = $urandom;
      @(negedge clk_i);
    end
    start    = 1'b1;
    cycles_i = n;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_splits.push_back(split_count(n));
  endtask

  always @(posedge clk_i) begin : result_check
    count_split_t want;
    if (rst_ni && done_o) begin
      if (expected_splits.size() == 0) begin
        $display("%0t: unexpected result beat p=%0d c=%0d", $time, prescaler_o, counter_o);
        failures++;
      end else begin
        want = expected_splits.pop_front();
        if (prescaler_o !== want.prescaler) begin
          $display("%0t: prescaler expected %0d got %0d", $time, want.prescaler, prescaler_o);
          failures++;
        end
        if (counter_o !== want.counter) begin
          $display("%0t: counter expected %0d got %0d", $time, want.counter, counter_o);
          failures++;
        end
        if (residual_o !== want.residual) begin
          $display("%0t: residual expected %0d got %0d", $time, want.residual, residual_o);
          failures++;
        end
        if (out_of_range_o !== want.out_of_range) begin
          $display("%0t: out_of_range expected %0b got %0b", $time, want.out_of_range,
                   out_of_range_o);
          failures++;
        end
      end
    end
  end

  // Zero and oversize counts, smallest counts, products at the limits,
  // empty searches and a winning round-up.
  task automatic test_directed_counts();
    logic [CyclesW-1:0] counts[$];
    counts = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd12345, 32'd65534, 32'd65535, 32'd65536,
               32'd131070, 32'd196563, 32'd4194240, 32'd4294639620, 32'd4294679620,
               32'd4294705155, 32'd4294705156, 32'd4294705157, 32'd4294770689,
               CyclesMax - 32'd1, CyclesMax, CyclesMax + 32'd1, 32'hffff_ffff};
    foreach (counts[i]) send_count(counts[i]);
  endtask

  // Exact products with a small prescaler: search ends early. No idling here.
  task automatic test_exact_products();
    logic [CyclesW-1:0] p, c;
    sender_idles = 1'b0;
    repeat (30) begin
      p = $urandom_range(64, 1);
      c = $urandom_range(65535, 1);
      send_count(p * c);
    end
    sender_idles = 1'b1;
  endtask

  // Near the top of the range: short searches, mostly nonzero residuals.
  task automatic test_top_band();
    repeat (25) send_count($urandom_range(CyclesMax, TopBandLow));
  endtask

  task automatic test_mixed_counts();
    int                 pick;
    logic [CyclesW-1:0] p, c;
    repeat (30) begin
      pick = $urandom_range(99);
      p    = $urandom_range(64, 1);
      c    = $urandom_range(65535, 1);
      if (pick < 45)      send_count(p * c);
      else if (pick < 75) send_count($urandom_range(CyclesMax, TopBandLow));
      else if (pick < 88) send_count($urandom_range(65535, 1));
      else if (pick < 94) send_count($urandom_range(32'hffff_ffff, CyclesMax + 32'd1));
      else                send_count(32'd0);
    end
  endtask

  initial begin
    rst_ni   = 1'b0;
    start    = 1'b0;
    cycles_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_counts();
    test_exact_products();
    test_top_band();
    test_mixed_counts();

    @(negedge clk_i);
    start = 1'b0;
    while (expected_splits.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("%0t: timeout, %0d results outstanding", $time, expected_splits.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sim.f
src/tpps_pkg.sv
src/tpps_div.sv
src/tpps_datapath.sv
src/tpps_ctrl.sv
src/timer_prescaler_period_search_core.sv
tb/tb_timer_prescaler_period_search_core.sv
